// ===== rtl/mutex_lock_table_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lock table
// Shared wrappers around concurrent assertions, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MUTEX_LOCK_TABLE_DEFINES_SVH
`define MUTEX_LOCK_TABLE_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define MLT_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("lock table: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define MLT_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("lock table: next-cycle check failed");

`endif

// ===== rtl/mlt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlt_pkg
// Types and codes shared by the lock table and its test bench.
// ----------------------------------------------------------------------------
package mlt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam logic [15:0] NO_OWNER = 16'hFFFF;

  // Request operation codes
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_ACQUIRE = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_TRY     = 3'd3;
  localparam logic [2:0] OP_CHECK   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] lock_id;
    logic [15:0]        requester_pid;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               held_now;
    logic signed [31:0] echo_id;
  } rsp_t;

  typedef struct packed {
    logic [31:0] name;
    logic        held;
    logic [15:0] owner;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

endpackage

// ===== rtl/mutex_lock_table.sv =====
// ----------------------------------------------------------------------------
// mutex_lock_table
// Table of named locks: create, acquire, release, try acquire and check.
// ----------------------------------------------------------------------------
// The block serves one request at a time and answers each with exactly one
// result. Entries live in a single RAM word each (name, held flag, owner pid).
// Entries are only ever claimed at the lowest free slot and never freed, so
// the valid entries always form a prefix of the RAM and a fill count replaces
// per-entry valid bits; reset empties the table at once, with no clearing
// pass. A request works through its steps in order: the cycle in which it
// is accepted issues the first read, each entry created so far (at most
// TABLE_DEPTH, 16 by default) is compared in turn through the RAM read
// port, and a final step writes back and loads the result register. The
// search stops early at the first matching entry. The result sits in an
// output register, so a new request is taken as soon as the previous one
// has been written back, even while its result still waits for out_ready;
// that next request then holds in its last cycle until the result register
// is free.
// ----------------------------------------------------------------------------
`include "mutex_lock_table_defines.svh"

module mutex_lock_table #(
  parameter int unsigned TABLE_DEPTH = mlt_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mlt_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output mlt_pkg::rsp_t out_rsp
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W = $bits(mlt_pkg::entry_t);

  // Control state
  mlt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;       // entries created so far
  logic             out_valid_r, out_valid_nxt;

  // Request context and scan bookkeeping
  mlt_pkg::req_t    req_r, req_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;       // next RAM address to read
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt; // address of the data now on rdata
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             hit_held_r, hit_held_nxt;
  mlt_pkg::rsp_t    rsp_r, rsp_nxt;

  // RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  mlt_pkg::entry_t  ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  mlt_pkg::entry_t  rd_ent;

  logic in_acc;
  logic fin_go;
  logic rd_match;
  logic rd_last;

  assign rd_ent   = mlt_pkg::entry_t'(ram_rdata);
  assign in_acc   = in_valid && in_ready;
  assign fin_go   = (state_r == mlt_pkg::S_FIN) && (!out_valid_r || out_ready);
  assign rd_match = (rd_ent.name == req_r.lock_id);
  assign rd_last  = (CNT_W'(rd_idx_r) == (cnt_r - CNT_W'(1)));

  mlt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    ptr_r      <= ptr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    found_r    <= found_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_held_r <= hit_held_nxt;
    rsp_r      <= rsp_nxt;
  end

  // Next state, scan control, write-back and result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    ptr_nxt       = ptr_r;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_held_nxt  = hit_held_r;
    rsp_nxt       = rsp_r;
    in_ready      = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = ptr_r;
    ram_we        = 1'b0;
    ram_waddr     = hit_idx_r;
    ram_wdata     = '{name: req_r.lock_id, held: 1'b0, owner: mlt_pkg::NO_OWNER};

    // Drop the result once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mlt_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = '0;
        if (in_valid) begin
          // Latch the request and start reading entry 0
          req_nxt    = in_req;
          found_nxt  = 1'b0;
          ram_re     = 1'b1;
          rd_idx_nxt = '0;
          ptr_nxt    = IDX_W'(1);
          state_nxt  = (cnt_r == '0) ? mlt_pkg::S_FIN : mlt_pkg::S_SCAN;
        end
      end

      mlt_pkg::S_SCAN: begin
        // Keep one read in flight per cycle while entries remain
        if (CNT_W'(ptr_r) < cnt_r) begin
          ram_re     = 1'b1;
          rd_idx_nxt = ptr_r;
          ptr_nxt    = ptr_r + IDX_W'(1);
        end
        if (rd_match) begin
          found_nxt    = 1'b1;
          hit_idx_nxt  = rd_idx_r;
          hit_held_nxt = rd_ent.held;
          state_nxt    = mlt_pkg::S_FIN;
        end else if (rd_last) begin
          state_nxt = mlt_pkg::S_FIN;
        end
      end

      mlt_pkg::S_FIN: begin
        if (fin_go) begin
          rsp_nxt.echo_id  = req_r.lock_id;
          rsp_nxt.status   = mlt_pkg::ST_DONE;
          rsp_nxt.held_now = 1'b0;
          if (req_r.req_type == mlt_pkg::OP_CREATE) begin
            if (found_r) begin
              rsp_nxt.held_now = hit_held_r;
            end else if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
              rsp_nxt.status = mlt_pkg::ST_FULL;
            end else begin
              // Claim the lowest free slot, unheld and unowned
              ram_we    = 1'b1;
              ram_waddr = cnt_r[IDX_W-1:0];
              cnt_nxt   = cnt_r + CNT_W'(1);
            end
          end else if (!found_r) begin
            rsp_nxt.status = mlt_pkg::ST_NOTFOUND;
          end else begin
            case (req_r.req_type) inside
              mlt_pkg::OP_ACQUIRE, mlt_pkg::OP_TRY: begin
                rsp_nxt.held_now = 1'b1;
                if (hit_held_r) begin
                  rsp_nxt.status = mlt_pkg::ST_BUSY;
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = '{name: req_r.lock_id, held: 1'b1,
                                owner: req_r.requester_pid};
                end
              end
              mlt_pkg::OP_RELEASE: begin
                if (!hit_held_r) begin
                  rsp_nxt.status = mlt_pkg::ST_BUSY;
                end else begin
                  ram_we = 1'b1;
                end
              end
              default: begin
                // Check held, and unused codes behave the same
                rsp_nxt.held_now = hit_held_r;
              end
            endcase
          end
          out_valid_nxt = 1'b1;
          state_nxt     = mlt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mlt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  `MLT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(TABLE_DEPTH))
  `MLT_ASSERT_SAME(a_we_in_fin, ram_we, fin_go)
  `MLT_ASSERT_NEXT(a_acc_busy, in_acc, state_r != mlt_pkg::S_IDLE)
  `MLT_ASSERT_NEXT(a_cnt_create, fin_go && (req_r.req_type != mlt_pkg::OP_CREATE),
                   $stable(cnt_r))

endmodule

// ===== rtl/mlt_ram.sv =====
// ----------------------------------------------------------------------------
// mlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sim/mutex_lock_table_test.sv =====
// ----------------------------------------------------------------------------
// mutex_lock_table_test
// Self-checking bench for the lock table. A directed table of requests
// fills the table and walks every operation and status. Random requests
// follow, mostly against names already created. Every result is checked
// field by field against a typed row's own result or the lock table model.
// ----------------------------------------------------------------------------
module mutex_lock_table_test;

  localparam int LOCK_SLOTS = mlt_pkg::TABLE_DEPTH_DEF;

  // Op codes the block does not define; they act as check held
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Source of the expected result for a directed row
  localparam bit EXP_TYPED = 1'b1;
  localparam bit EXP_MODEL = 1'b0;

  localparam int REPORT_LIMIT = 10;
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mlt_pkg::req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mlt_pkg::rsp_t out_rsp;

  // Model of the lock table, updated on every accepted request
  bit          slot_valid [LOCK_SLOTS] = '{default: 1'b0};
  logic [31:0] slot_name  [LOCK_SLOTS] = '{default: '0};
  bit          slot_held  [LOCK_SLOTS] = '{default: 1'b0};
  logic [31:0] created_names [$];

  // Results still owed by the block, oldest first
  mlt_pkg::rsp_t owed_rsp [$];
  int   fail_count = 0;

  // Idle percentages for request and result side
  int send_idle_pct = 25;
  int recv_idle_pct = 75;

  // Long result-side hold-off, started once by the main process
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  typedef struct {
    mlt_pkg::req_t req;
    bit            src;
    logic [1:0]    status;
    logic          held;
  } dir_row_t;

  // Directed requests. Typed rows carry their expected status and held flag;
  // the echoed id is always the request's lock id.
  dir_row_t dir_rows [28] = '{
    // check on an empty table
    '{'{mlt_pkg::OP_CHECK,   32'sh00000000, 16'h0000}, EXP_TYPED, mlt_pkg::ST_NOTFOUND, 1'b0},
    // create the two extreme names
    '{'{mlt_pkg::OP_CREATE,  32'sh80000000, 16'hFFFF}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh7FFFFFFF, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    // acquire, then acquire and try on a held lock
    '{'{mlt_pkg::OP_ACQUIRE, 32'sh80000000, 16'hFFFF}, EXP_MODEL, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_ACQUIRE, 32'sh80000000, 16'h0000}, EXP_MODEL, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_TRY,     32'sh80000000, 16'h1234}, EXP_MODEL, mlt_pkg::ST_DONE,     1'b0},
    // create of a present, held name
    '{'{mlt_pkg::OP_CREATE,  32'sh80000000, 16'h0001}, EXP_MODEL, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CHECK,   32'sh80000000, 16'h0000}, EXP_MODEL, mlt_pkg::ST_DONE,     1'b0},
    // release twice: the second one finds the lock free
    '{'{mlt_pkg::OP_RELEASE, 32'sh80000000, 16'h0000}, EXP_MODEL, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_RELEASE, 32'sh80000000, 16'h0000}, EXP_TYPED, mlt_pkg::ST_BUSY,     1'b0},
    // try on a free lock, then an unused op code on it
    '{'{mlt_pkg::OP_TRY,     32'sh7FFFFFFF, 16'h0000}, EXP_MODEL, mlt_pkg::ST_DONE,     1'b0},
    '{'{OP_SPARE_FIRST,      32'sh7FFFFFFF, 16'hAAAA}, EXP_MODEL, mlt_pkg::ST_DONE,     1'b0},
    // release of an unknown name
    '{'{mlt_pkg::OP_RELEASE, 32'shFFFFFFFF, 16'h5555}, EXP_TYPED, mlt_pkg::ST_NOTFOUND, 1'b0},
    // fill the remaining fourteen slots
    '{'{mlt_pkg::OP_CREATE,  32'shFFFFFFFF, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh00000000, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh55555555, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'shAAAAAAAA, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh0000FFFF, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'shFFFF0000, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh00000001, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'shFFFFFFFE, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh12345678, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh0F0F0F0F, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'shF0F0F0F0, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh40000000, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'shBFFFFFFF, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    '{'{mlt_pkg::OP_CREATE,  32'sh80000001, 16'h0000}, EXP_TYPED, mlt_pkg::ST_DONE,     1'b0},
    // one more name does not fit
    '{'{mlt_pkg::OP_CREATE,  32'sh00000002, 16'h0000}, EXP_TYPED, mlt_pkg::ST_FULL,     1'b0}
  };

  mutex_lock_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always #5 clk = ~clk;

  // Apply one request to the lock table model and return its result.
  function automatic mlt_pkg::rsp_t lock_outcome(input mlt_pkg::req_t r);
    int            hit;
    int            free_slot;
    mlt_pkg::rsp_t res;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (hit < 0 && slot_valid[i] && slot_name[i] == r.lock_id) hit = i;
      if (free_slot < 0 && !slot_valid[i]) free_slot = i;
    end
    res.status = mlt_pkg::ST_DONE;
    res.held_now = 1'b0;
    res.echo_id = r.lock_id;
    if (r.req_type == mlt_pkg::OP_CREATE) begin
      if (hit >= 0) begin
        res.held_now = slot_held[hit];
      end else if (free_slot < 0) begin
        res.status = mlt_pkg::ST_FULL;
      end else begin
        slot_valid[free_slot] = 1'b1;
        slot_name[free_slot] = r.lock_id;
        slot_held[free_slot] = 1'b0;
        created_names.push_back(r.lock_id);
      end
    end else if (hit < 0) begin
      res.status = mlt_pkg::ST_NOTFOUND;
    end else if (r.req_type == mlt_pkg::OP_ACQUIRE || r.req_type == mlt_pkg::OP_TRY) begin
      if (slot_held[hit]) begin
        res.status = mlt_pkg::ST_BUSY;
      end else begin
        slot_held[hit] = 1'b1;
      end
      res.held_now = 1'b1;
    end else if (r.req_type == mlt_pkg::OP_RELEASE) begin
      if (!slot_held[hit]) begin
        res.status = mlt_pkg::ST_BUSY;
      end else begin
        slot_held[hit] = 1'b0;
      end
    end else begin
      // check held; the unused op codes act the same way
      res.held_now = slot_held[hit];
    end
    return res;
  endfunction

  // Offer one request, hold it until the handshake, then record the result
  // the block owes for it. Idle cycles go in front of the request, so a
  // request that follows without a gap keeps in_valid high across the edge.
  task automatic send_request(input mlt_pkg::req_t r, input bit use_typed,
                              input mlt_pkg::rsp_t typed_rsp);
    mlt_pkg::rsp_t model_rsp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Advance the model even for typed rows so later requests see its state.
    model_rsp = lock_outcome(r);
    owed_rsp.push_back(use_typed ? typed_rsp : model_rsp);
  endtask

  // Result side: random stalls, plus one long hold-off that lets the block
  // fill up and push back on the request side.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready <= 1'b0;
      hold_taken <= 1'b1;
      hold_left <= RSP_HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest owed one.
  always @(posedge clk) begin
    mlt_pkg::rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_rsp.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: status %0d held %0d id %h",
                   out_rsp.status, out_rsp.held_now, out_rsp.echo_id);
      end else begin
        want = owed_rsp.pop_front();
        if (out_rsp.status !== want.status || out_rsp.held_now !== want.held_now ||
            out_rsp.echo_id !== want.echo_id) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"result mismatch: want status %0d held %0d id %h,",
                      " got status %0d held %0d id %h"},
                     want.status, want.held_now, want.echo_id,
                     out_rsp.status, out_rsp.held_now, out_rsp.echo_id);
        end
      end
    end
  end

  initial begin
    mlt_pkg::rsp_t typed_rsp;
    mlt_pkg::req_t r;
    int   roll;
    int   phase_items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    foreach (dir_rows[i]) begin
      typed_rsp.status = dir_rows[i].status;
      typed_rsp.held_now = dir_rows[i].held;
      typed_rsp.echo_id = dir_rows[i].req.lock_id;
      send_request(dir_rows[i].req, dir_rows[i].src == EXP_TYPED, typed_rsp);
    end

    // Random requests in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        // Hold the request side until every owed result is back.
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_rsp.size() != 0) @(posedge clk);
        send_idle_pct = 75;
        recv_idle_pct = 25;
        phase_items = 600;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= 1'b1;
        phase_items = 550;
      end else begin
        phase_items = 600;
      end
      for (int n = 0; n < phase_items; n++) begin
        // Mostly lock and unlock traffic on names that exist; a few creates,
        // checks, unused op codes and unknown names.
        roll = $urandom_range(0, 99);
        if (roll < 8)       r.req_type = mlt_pkg::OP_CREATE;
        else if (roll < 30) r.req_type = mlt_pkg::OP_ACQUIRE;
        else if (roll < 55) r.req_type = mlt_pkg::OP_RELEASE;
        else if (roll < 78) r.req_type = mlt_pkg::OP_TRY;
        else if (roll < 92) r.req_type = mlt_pkg::OP_CHECK;
        else                r.req_type = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if (created_names.size() != 0 && $urandom_range(0, 99) < 80)
          r.lock_id = created_names[$urandom_range(0, created_names.size() - 1)];
        else
          r.lock_id = $urandom();
        r.requester_pid = 16'($urandom_range(0, 65535));
        send_request(r, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then give a late or stray result time to show up.
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_rsp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
